// ----- hdl/gpioe_pkg.sv -----
// Shared types and constants for the GPIO bank with edge interrupts.
// No dependencies; used by the core, the top level and the checker.
package gpioe_pkg;

  localparam int PINS_PER_BANK = 16;
  localparam int PIN_COUNT = (PINS_PER_BANK < 16) ? PINS_PER_BANK : 16;

  // bits at or above PIN_COUNT (2*PIN_COUNT for edge) stay zero
  localparam logic [15:0] PIN_MASK  = 16'((17'(1) << PIN_COUNT) - 17'(1));
  localparam logic [31:0] EDGE_MASK = 32'((33'(1) << (2 * PIN_COUNT)) - 33'(1));

  // word kinds
  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_SAMPLE = 2'd2;

  // register selects
  localparam logic [3:0] REG_DATAIN  = 4'd0;
  localparam logic [3:0] REG_DIR     = 4'd1;
  localparam logic [3:0] REG_SET_OUT = 4'd2;
  localparam logic [3:0] REG_CLR_OUT = 4'd3;
  localparam logic [3:0] REG_EDGE_LO = 4'd4;
  localparam logic [3:0] REG_EDGE_HI = 4'd5;
  localparam logic [3:0] REG_STATUS  = 4'd6;
  localparam logic [3:0] REG_SET_EN  = 4'd7;
  localparam logic [3:0] REG_CLR_EN  = 4'd8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  reg_select;
    logic [15:0] write_data;
    logic [15:0] pin_levels;
  } gpioe_cmd_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [15:0] data_out;
    logic [15:0] output_enable;
    logic        irq;
    logic [15:0] irq_pending;
  } gpioe_res_t;

endpackage

// ----- hdl/gpioe_core.sv -----
// Register file and per-word update logic of the GPIO bank.
// Depends on gpioe_pkg. Applies one word per cycle when step is high.
module gpioe_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  gpioe_pkg::gpioe_cmd_t  cmd,
  output gpioe_pkg::gpioe_res_t  res
);

  logic [15:0] dir_r, dir_nxt;
  logic [15:0] latch_r, latch_nxt;
  logic [31:0] edge_r, edge_nxt;
  logic [15:0] stat_r, stat_nxt;
  logic [15:0] en_r, en_nxt;
  logic [15:0] prev_r, prev_nxt;

  logic [15:0] rd;
  logic [15:0] cur_pins;
  logic [15:0] rise;
  logic [15:0] fall;
  logic [15:0] hit;

  assign cur_pins = cmd.pin_levels & gpioe_pkg::PIN_MASK;
  assign rise     = ~prev_r & cur_pins;
  assign fall     = prev_r & ~cur_pins;

  always_comb begin
    hit = '0;
    for (int p = 0; p < gpioe_pkg::PIN_COUNT; p++) begin
      hit[p] = (rise[p] & edge_r[2*p+1]) | (fall[p] & edge_r[2*p]);
    end
  end

  always_comb begin
    dir_nxt   = dir_r;
    latch_nxt = latch_r;
    edge_nxt  = edge_r;
    stat_nxt  = stat_r;
    en_nxt    = en_r;
    prev_nxt  = prev_r;
    rd        = '0;
    case (cmd.kind)
      gpioe_pkg::KIND_READ: begin
        unique case (cmd.reg_select)
          gpioe_pkg::REG_DATAIN:  rd = prev_r;
          gpioe_pkg::REG_DIR:     rd = dir_r;
          gpioe_pkg::REG_SET_OUT,
          gpioe_pkg::REG_CLR_OUT: rd = latch_r;
          gpioe_pkg::REG_EDGE_LO: rd = edge_r[15:0];
          gpioe_pkg::REG_EDGE_HI: rd = edge_r[31:16];
          gpioe_pkg::REG_STATUS:  rd = stat_r;
          gpioe_pkg::REG_SET_EN,
          gpioe_pkg::REG_CLR_EN:  rd = en_r;
          default:                rd = '0;
        endcase
      end
      gpioe_pkg::KIND_WRITE: begin
        unique case (cmd.reg_select)
          gpioe_pkg::REG_DIR:     dir_nxt = cmd.write_data & gpioe_pkg::PIN_MASK;
          gpioe_pkg::REG_SET_OUT: latch_nxt = (latch_r | cmd.write_data) & gpioe_pkg::PIN_MASK;
          gpioe_pkg::REG_CLR_OUT: latch_nxt = latch_r & ~cmd.write_data & gpioe_pkg::PIN_MASK;
          gpioe_pkg::REG_EDGE_LO:
            edge_nxt = {edge_r[31:16], cmd.write_data} & gpioe_pkg::EDGE_MASK;
          gpioe_pkg::REG_EDGE_HI:
            edge_nxt = {cmd.write_data, edge_r[15:0]} & gpioe_pkg::EDGE_MASK;
          gpioe_pkg::REG_STATUS:  stat_nxt = stat_r & ~cmd.write_data & gpioe_pkg::PIN_MASK;
          gpioe_pkg::REG_SET_EN:  en_nxt = (en_r | cmd.write_data) & gpioe_pkg::PIN_MASK;
          gpioe_pkg::REG_CLR_EN:  en_nxt = en_r & ~cmd.write_data & gpioe_pkg::PIN_MASK;
          default: ;  // datain and unknown selects ignore writes
        endcase
      end
      gpioe_pkg::KIND_SAMPLE: begin
        // edges on output pins are masked off by the direction mask
        stat_nxt = (stat_r | (hit & dir_r)) & gpioe_pkg::PIN_MASK;
        prev_nxt = cur_pins;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r   <= gpioe_pkg::PIN_MASK;
      latch_r <= '0;
      edge_r  <= '0;
      stat_r  <= '0;
      en_r    <= '0;
      prev_r  <= '0;
    end else if (step) begin
      dir_r   <= dir_nxt;
      latch_r <= latch_nxt;
      edge_r  <= edge_nxt;
      stat_r  <= stat_nxt;
      en_r    <= en_nxt;
      prev_r  <= prev_nxt;
    end
  end

  // result shows the state after the word
  assign res.read_data     = rd;
  assign res.data_out      = latch_nxt;
  assign res.output_enable = ~dir_nxt & gpioe_pkg::PIN_MASK;
  assign res.irq           = |(stat_nxt & en_nxt);
  assign res.irq_pending   = stat_nxt;

endmodule

// ----- hdl/gpio_bank_edge_interrupts.sv -----
// Top level of the 16-pin GPIO bank with edge interrupts.
// Depends on gpioe_pkg and gpioe_core.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word per access: a bus
//   read, a bus write or a pin-sample tick, with in_reg_select, in_write_data
//   and in_pin_levels. Every accepted word yields exactly one result word on
//   the output channel (out_valid/out_ready): the read value (zero unless a
//   read), the output latch, drive enables, the interrupt line and the
//   pending status bits, all as they stand after that word.
//   Path: an accepted word is captured in the input register, then passes
//   through the update logic into the result register, which drives out_valid.
//   Throughput: one word per cycle while out_ready stays high; the register
//   file and update logic take a word whenever the input register advances.
//   Reset (rst_n low, synchronous): all pins inputs, latch, edge control,
//   status, enables and last sampled pins cleared; both stages emptied.
//   Stall: when out_ready is low the result register holds its word and the
//   input register holds one more; in_ready drops once both are full.
module gpio_bank_edge_interrupts (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [3:0]  in_reg_select,
  input  logic [15:0] in_write_data,
  input  logic [15:0] in_pin_levels,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_read_data,
  output logic [15:0] out_data_out,
  output logic [15:0] out_output_enable,
  output logic        out_irq,
  output logic [15:0] out_irq_pending
);

  logic                  s1_valid_r;
  gpioe_pkg::gpioe_cmd_t s1_cmd_r;
  logic                  out_valid_r;
  gpioe_pkg::gpioe_res_t out_res_r;
  gpioe_pkg::gpioe_res_t res;
  logic                  s1_adv;

  // stage 1 moves into the result register when that slot is free or leaving
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r.kind       <= in_kind;
      s1_cmd_r.reg_select <= in_reg_select;
      s1_cmd_r.write_data <= in_write_data;
      s1_cmd_r.pin_levels <= in_pin_levels;
    end
  end

  gpioe_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_adv),
    .cmd   (s1_cmd_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_res_r.read_data;
  assign out_data_out      = out_res_r.data_out;
  assign out_output_enable = out_res_r.output_enable;
  assign out_irq           = out_res_r.irq;
  assign out_irq_pending   = out_res_r.irq_pending;

endmodule

// ----- hdl/gpioe_checker.sv -----
// Port-level checker for gpio_bank_edge_interrupts, bound to the top level.
// Depends on gpioe_pkg.
module gpioe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_read_data,
  input logic [15:0] out_data_out,
  input logic [15:0] out_output_enable,
  input logic        out_irq,
  input logic [15:0] out_irq_pending
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data)
      && $stable(out_data_out) && $stable(out_output_enable)
      && $stable(out_irq) && $stable(out_irq_pending))
    else $error("result word changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // interrupt line needs a pending bit behind it
  a_irq_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_irq |-> out_irq_pending != 16'd0)
    else $error("irq without pending status");

  // pins beyond the bank never show up
  a_pin_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data_out | out_output_enable | out_irq_pending)
      & ~gpioe_pkg::PIN_MASK) == 16'd0)
    else $error("bit set beyond bank pins");

  // right after reset, with both stages empty, the block must take a word
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> in_ready)
    else $error("not ready after reset");

endmodule

bind gpio_bank_edge_interrupts gpioe_checker u_gpioe_checker (.*);
